// File: design/rld_pkg.sv
// Shared types and constants for the render lag detector.
`default_nettype none
package rld_pkg;

  localparam int unsigned WIN_W   = 16;
  localparam int unsigned RATIO_W = 11;
  localparam int unsigned TRIP_W  = 8;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned RATE_W  = 24;
  localparam int unsigned EVT_W   = 2;
  localparam int unsigned IDX_W   = 3;

  // Numerator of the achieved rate is frame_count * 256000.
  localparam int unsigned NUM_W     = 34;
  localparam int unsigned DIV_STEPS = NUM_W;
  localparam int unsigned DCNT_W    = 6;

  // Expected rate times a ratio, then that times the window.
  localparam int unsigned PART_W = RATE_W + RATIO_W;
  localparam int unsigned THR_W  = PART_W + WIN_W;

  localparam logic [IDX_W-1:0] REG_WINDOW_MS   = 3'd0;
  localparam logic [IDX_W-1:0] REG_LAG_RATIO   = 3'd1;
  localparam logic [IDX_W-1:0] REG_REC_RATIO   = 3'd2;
  localparam logic [IDX_W-1:0] REG_DROP_RATIO  = 3'd3;
  localparam logic [IDX_W-1:0] REG_TRIP_WINDOW = 3'd4;

  localparam logic [EVT_W-1:0] EVT_NONE      = 2'd0;
  localparam logic [EVT_W-1:0] EVT_LAG       = 2'd1;
  localparam logic [EVT_W-1:0] EVT_RECOVERED = 2'd2;

  localparam logic [TRIP_W-1:0] RUN_MAX = 8'd255;

  typedef struct packed {
    logic              busy;
    logic [RATE_W-1:0] quot;
  } div_stat_t;

endpackage
`default_nettype wire

// File: design/rld_div.sv
// Restoring divider, one quotient bit per cycle, with a saturated quotient.
`default_nettype none
module rld_div (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [rld_pkg::NUM_W-1:0]    numer,
  input  wire logic [rld_pkg::WIN_W-1:0]    denom,
  output rld_pkg::div_stat_t                stat
);

  logic [rld_pkg::DCNT_W-1:0] cnt;
  logic [rld_pkg::WIN_W-1:0]  rem;
  logic [rld_pkg::NUM_W-1:0]  nq;
  logic [rld_pkg::WIN_W-1:0]  dvs;
  logic [rld_pkg::WIN_W:0]    rem_sh;
  logic                       ge;

  assign rem_sh = {rem, nq[rld_pkg::NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= rld_pkg::DCNT_W'(rld_pkg::DIV_STEPS);
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      nq  <= numer;
      dvs <= denom;
    end else if (cnt != '0) begin
      rem <= ge ? rem_sh[rld_pkg::WIN_W-1:0] - dvs : rem_sh[rld_pkg::WIN_W-1:0];
      nq  <= {nq[rld_pkg::NUM_W-2:0], ge};
    end
  end

  assign stat.busy = cnt != '0;
  assign stat.quot = (|nq[rld_pkg::NUM_W-1:rld_pkg::RATE_W]) ? '1
                                                            : nq[rld_pkg::RATE_W-1:0];

endmodule
`default_nettype wire

// File: design/render_lag_detector_unit.sv
// Top level of the render lag detector: sequencer, shared multiplier and run state.
//
//   channel  direction  handshake            payload
//   in       to block   in_valid / in_stall  frame_count dropped_count rate_known expected_rate
//   out      from block out_valid / out_stall event_res achieved_valid achieved_rate
//   cfg      to block   cfg_valid / cfg_ready cfg_index cfg_data
//
// An evaluated window computes the achieved rate with the 34-step restoring divider;
// the six threshold products share one multiplier while the divider runs, and the result
// is finished once both are done and the output register is free.
// A window that is skipped (zero window, unknown rate, idle start) does not start the
// divider and goes straight to the finish state. A new request is taken only in the idle state.
// Reset is synchronous, clears all control and run state and loads the register defaults.
// A finished result waits in the output register while the next request is taken.
`default_nettype none
module render_lag_detector_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [rld_pkg::CNT_W-1:0]     frame_count,
  input  wire logic [rld_pkg::CNT_W-1:0]     dropped_count,
  input  wire logic                          rate_known,
  input  wire logic [rld_pkg::RATE_W-1:0]    expected_rate,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [rld_pkg::EVT_W-1:0]          event_res,
  output logic                               achieved_valid,
  output logic [rld_pkg::RATE_W-1:0]         achieved_rate,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [rld_pkg::IDX_W-1:0]     cfg_index,
  input  wire logic [rld_pkg::WIN_W-1:0]     cfg_data
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;
  localparam logic [2:0] LAST_STEP = 3'd5;

  logic [1:0] state;
  logic [2:0] step;
  logic       eval;

  logic [rld_pkg::WIN_W-1:0]   win_len;
  logic [rld_pkg::RATIO_W-1:0] slow_q10;
  logic [rld_pkg::RATIO_W-1:0] rec_ratio;
  logic [rld_pkg::RATIO_W-1:0] drop_q10;
  logic [rld_pkg::TRIP_W-1:0]  trip_count;

  logic                        lagging;
  logic [rld_pkg::TRIP_W-1:0]  slow_run;
  logic [rld_pkg::TRIP_W-1:0]  good_run;
  logic                        prev_rate_valid;
  logic [rld_pkg::RATE_W-1:0]  prev_rate;
  logic                        seen_frames;

  logic [rld_pkg::CNT_W-1:0]   frames;
  logic [rld_pkg::CNT_W-1:0]   dropped;
  logic [rld_pkg::RATE_W-1:0]  expected;
  logic [rld_pkg::PART_W-1:0]  part;
  logic [rld_pkg::THR_W-1:0]   lag_thr;
  logic [rld_pkg::THR_W-1:0]   rec_thr;
  logic [rld_pkg::THR_W-1:0]   drop_thr;

  logic [rld_pkg::PART_W-1:0]  mul_a;
  logic [rld_pkg::WIN_W-1:0]   mul_b;
  logic [rld_pkg::THR_W-1:0]   prod;

  logic                        in_acc;
  logic                        out_free;
  logic                        div_start;
  logic [rld_pkg::NUM_W-1:0]   numer;
  rld_pkg::div_stat_t          div_stat;

  logic [25:0]                 frames_k;
  logic [25:0]                 dropped_k;
  logic [rld_pkg::THR_W-1:0]   fscaled;
  logic [rld_pkg::THR_W-1:0]   dscaled;
  logic [rld_pkg::THR_W-1:0]   dscaled2;
  logic                        slow;
  logic                        dropping;
  logic                        good;
  logic [rld_pkg::TRIP_W-1:0]  slow_inc;
  logic [rld_pkg::TRIP_W-1:0]  good_inc;

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = state != S_IDLE;
  assign cfg_ready = state == S_IDLE;
  assign out_free  = !out_valid || !out_stall;

  assign div_start = in_acc && win_len != '0 && rate_known && expected_rate != '0
                     && (frame_count != '0 || seen_frames);
  assign numer = {26'(frame_count) * 26'd1000, 8'd0};

  rld_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .numer (numer),
    .denom (win_len),
    .stat  (div_stat)
  );

  always_comb begin
    case (step)
      3'd0:    begin mul_a = rld_pkg::PART_W'(expected); mul_b = 16'(slow_q10);  end
      3'd2:    begin mul_a = rld_pkg::PART_W'(expected); mul_b = 16'(rec_ratio); end
      3'd4:    begin mul_a = rld_pkg::PART_W'(expected); mul_b = 16'(drop_q10);  end
      default: begin mul_a = part;                       mul_b = win_len;        end
    endcase
  end

  assign prod = rld_pkg::THR_W'(mul_a) * rld_pkg::THR_W'(mul_b);

  assign frames_k  = 26'(frames) * 26'd1000;
  assign dropped_k = 26'(dropped) * 26'd1000;
  assign fscaled   = rld_pkg::THR_W'({frames_k, 18'd0});
  assign dscaled   = rld_pkg::THR_W'({dropped_k, 18'd0});
  assign dscaled2  = rld_pkg::THR_W'({dropped_k, 19'd0});
  assign slow      = fscaled < lag_thr;
  assign dropping  = dscaled > drop_thr;
  assign good      = fscaled >= rec_thr && dscaled2 <= drop_thr;
  assign slow_inc  = (slow_run == rld_pkg::RUN_MAX) ? slow_run : slow_run + 1'b1;
  assign good_inc  = (good_run == rld_pkg::RUN_MAX) ? good_run : good_run + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_len    <= 16'd2000;
      slow_q10   <= 11'd870;
      rec_ratio  <= 11'd973;
      drop_q10   <= 11'd51;
      trip_count <= 8'd3;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rld_pkg::REG_WINDOW_MS:   win_len    <= cfg_data;
        rld_pkg::REG_LAG_RATIO:   slow_q10   <= cfg_data[rld_pkg::RATIO_W-1:0];
        rld_pkg::REG_REC_RATIO:   rec_ratio  <= cfg_data[rld_pkg::RATIO_W-1:0];
        rld_pkg::REG_DROP_RATIO:  drop_q10   <= cfg_data[rld_pkg::RATIO_W-1:0];
        rld_pkg::REG_TRIP_WINDOW: trip_count <= cfg_data[rld_pkg::TRIP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      frames   <= frame_count;
      dropped  <= dropped_count;
      expected <= expected_rate;
    end
    if (state == S_MUL) begin
      case (step)
        3'd1:    lag_thr  <= prod;
        3'd3:    rec_thr  <= prod;
        3'd5:    drop_thr <= prod;
        default: part     <= prod[rld_pkg::PART_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      step            <= '0;
      eval            <= 1'b0;
      lagging         <= 1'b0;
      slow_run        <= '0;
      good_run        <= '0;
      prev_rate_valid <= 1'b0;
      prev_rate       <= '0;
      seen_frames     <= 1'b0;
      out_valid       <= 1'b0;
      event_res       <= rld_pkg::EVT_NONE;
      achieved_valid  <= 1'b0;
      achieved_rate   <= '0;
    end else begin
      if (state == S_FIN && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            step  <= '0;
            eval  <= div_start;
            state <= div_start ? S_MUL : S_FIN;
            if (win_len == '0) begin
            end else if (!rate_known || expected_rate == '0) begin
              slow_run        <= '0;
              good_run        <= '0;
              prev_rate_valid <= 1'b0;
            end else if (frame_count == '0 && !seen_frames) begin
              slow_run        <= '0;
              good_run        <= '0;
              prev_rate_valid <= 1'b1;
              prev_rate       <= expected_rate;
            end else begin
              if (frame_count != '0) begin
                seen_frames <= 1'b1;
              end
              if (prev_rate_valid && expected_rate != prev_rate) begin
                slow_run <= '0;
                good_run <= '0;
              end
              prev_rate_valid <= 1'b1;
              prev_rate       <= expected_rate;
            end
          end
        end
        S_MUL: begin
          step <= step + 1'b1;
          if (step == LAST_STEP) begin
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (!div_stat.busy) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            state <= S_IDLE;
            if (!eval) begin
              event_res      <= rld_pkg::EVT_NONE;
              achieved_valid <= 1'b0;
              achieved_rate  <= '0;
            end else begin
              achieved_valid <= 1'b1;
              achieved_rate  <= div_stat.quot;
              if (slow || dropping) begin
                slow_run <= slow_inc;
                good_run <= '0;
                if (!lagging && slow_inc >= trip_count) begin
                  lagging   <= 1'b1;
                  event_res <= rld_pkg::EVT_LAG;
                end else begin
                  event_res <= rld_pkg::EVT_NONE;
                end
              end else if (good) begin
                good_run <= good_inc;
                slow_run <= '0;
                if (lagging && good_inc >= trip_count) begin
                  lagging   <= 1'b0;
                  event_res <= rld_pkg::EVT_RECOVERED;
                end else begin
                  event_res <= rld_pkg::EVT_NONE;
                end
              end else begin
                slow_run  <= '0;
                good_run  <= '0;
                event_res <= rld_pkg::EVT_NONE;
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: design/rld_checker.sv
// Port-level checks for the render lag detector and their binding.
`default_nettype none
module rld_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_valid,
  input wire logic                          in_stall,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic [rld_pkg::EVT_W-1:0]     event_res,
  input wire logic                          achieved_valid,
  input wire logic [rld_pkg::RATE_W-1:0]    achieved_rate
);

  a_event_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (event_res == rld_pkg::EVT_NONE || event_res == rld_pkg::EVT_LAG ||
                   event_res == rld_pkg::EVT_RECOVERED))
    else $error("Result carries an undefined event code.");

  a_skip_is_empty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !achieved_valid) |-> (achieved_rate == '0 && event_res == rld_pkg::EVT_NONE))
    else $error("A skipped window reported a rate or an event.");

  a_busy_after_request: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("A new request was taken in the cycle after a request.");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(achieved_rate) && $stable(event_res)))
    else $error("A stalled result changed or vanished.");

endmodule

bind render_lag_detector_unit rld_checker u_rld_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .event_res      (event_res),
  .achieved_valid (achieved_valid),
  .achieved_rate  (achieved_rate)
);
`default_nettype wire
